// ===== sv/kbt_pkg.sv =====
// Shared types, codes and helpers for the keyboard event tracker.
`default_nettype none
package kbt_pkg;

    localparam logic [3:0] FN_EVENT  = 4'd0;
    localparam logic [3:0] FN_POP    = 4'd1;
    localparam logic [3:0] FN_DOWNS  = 4'd2;
    localparam logic [3:0] FN_UPS    = 4'd3;
    localparam logic [3:0] FN_FRAC   = 4'd4;
    localparam logic [3:0] FN_FLUSH  = 4'd5;
    localparam logic [3:0] FN_LVLCLR = 4'd6;
    localparam logic [3:0] FN_LVLRD  = 4'd7;
    localparam logic [3:0] FN_FILTER = 4'd8;

    localparam logic CFG_FILTER_COUNT = 1'b0;
    localparam logic CFG_DEBUG_SCAN   = 1'b1;

    localparam logic [16:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic        down;
        logic [31:0] went;
        logic [31:0] held;
        logic [31:0] checked;
        logic [15:0] dcnt;
        logic [15:0] ucnt;
    } t_key_row;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

// ===== sv/keyboard_event_tracker_core.sv =====
// Keyboard event tracker: per-key table, code FIFO, filter and held fraction.
//
// Input channel (i_valid/o_ready) carries one request; each request yields
// exactly one result on the output channel (o_valid/i_ready). Config writes
// use i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; always ready.
// A request walks a sequencer: two key-table reads (debug key, then the key),
// an execute state and a result state. A press that must pass the filter
// scans the filter slots in turn, up to FILTER_SLOTS of them. A held-fraction
// query that divides waits in ST_DIV for the serial divider. Flush sweeps the
// key table and level clear the level counts, one row a cycle. One request
// is in flight at a time. After reset a clearing pass zeroes the key table
// and level counts; o_ready stays low until it ends. Config writes are
// taken anyway. The result sits in an output register; a stalled receiver
// holds it, and the sequencer waits with the next result until the register
// is taken.
`default_nettype none
module keyboard_event_tracker_core
    import kbt_pkg::*;
#(
    parameter int KEYS         = 512,
    parameter int FIFO_DEPTH   = 16,
    parameter int FILTER_SLOTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_func,
    input  wire logic [8:0]  i_scancode,
    input  wire logic        i_key_down,
    input  wire logic        i_shift_held,
    input  wire logic        i_alt_held,
    input  wire logic        i_ctrl_held,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [15:0] i_latency_ms,
    input  wire logic [5:0]  i_filter_slot,
    input  wire logic [15:0] i_filter_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_value,
    output logic [16:0]      o_held_fraction,
    output logic             o_queue_nonempty,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    localparam int KW  = $clog2(KEYS);
    localparam int PW  = $clog2(FIFO_DEPTH);
    localparam int FW  = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
    localparam int FCW = $clog2(FILTER_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_DBG, ST_KEY, ST_EXEC, ST_FSCAN, ST_DIV, ST_RES
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_func;
    logic [8:0]  r_key;
    logic        r_kdown, r_shift, r_alt, r_ctrl;
    logic [31:0] r_now;
    logic [15:0] r_lat;
    logic [5:0]  r_fslot;
    logic [15:0] r_fcode;
    logic        r_dbg_down, n_dbg_down;
    logic [15:0] r_code, n_code;
    logic [15:0] r_value, n_value;
    logic [16:0] r_frac, n_frac;
    logic [PW-1:0]  r_rptr, n_rptr, r_wptr, n_wptr;
    logic [FCW-1:0] r_fidx, n_fidx;
    logic        r_fvalid, n_fvalid;
    logic [KW-1:0] r_clr_idx, n_clr_idx;
    logic        r_clr_key, n_clr_key, r_clr_lvl, n_clr_lvl, r_clr_item, n_clr_item;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_oval, n_oval;
    logic [16:0] r_ofrac, n_ofrac;
    logic        r_onon, n_onon;
    logic [6:0]  r_filter_count;
    logic [8:0]  r_debug;

    t_key_row    key_mem [KEYS];
    t_key_row    r_key_rd;
    logic [15:0] lvl_mem [KEYS];
    logic [15:0] r_lvl_rd;
    logic [15:0] fifo_mem [FIFO_DEPTH];
    logic [15:0] r_fifo_rd;
    logic [15:0] filt_mem [FILTER_SLOTS];
    logic [15:0] r_filt_rd;

    logic [KW-1:0] key_raddr, key_waddr, lvl_waddr;
    logic          key_we, lvl_we, fifo_we, filt_we;
    t_key_row      key_wdata;
    logic [15:0]   lvl_wdata;
    logic [15:0]   fifo_wdata;
    logic [FW-1:0] filt_raddr, filt_waddr;

    logic          div_start, div_done;
    logic [31:0]   div_num, div_den;
    logic [15:0]   div_quot;

    logic [KW-1:0] kidx, didx;
    logic          kok, dok, knz, full;
    logic [PW-1:0] wnext, rnext;
    logic [31:0]   ev_t, delta, held;
    logic [8:0]    nlim;
    logic [15:0]   code;
    t_key_row      w;

    assign kidx  = r_key[KW-1:0];
    assign didx  = r_debug[KW-1:0];
    assign kok   = {1'b0, r_key} < 10'(KEYS);
    assign dok   = {1'b0, r_debug} < 10'(KEYS);
    assign knz   = r_key != 9'd0;
    assign wnext = (r_wptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
    assign rnext = (r_rptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
    assign full  = wnext == r_rptr;
    assign ev_t  = r_now - {16'd0, r_lat};
    assign nlim  = ({2'b0, r_filter_count} > 9'(FILTER_SLOTS))
                   ? 9'(FILTER_SLOTS) : {2'b0, r_filter_count};
    assign filt_raddr = r_fidx[FW-1:0];
    assign filt_waddr = FW'(r_fslot);

    assign o_ready          = r_state == ST_IDLE;
    assign o_valid          = r_ovalid;
    assign o_value          = r_oval;
    assign o_held_fraction  = r_ofrac;
    assign o_queue_nonempty = r_onon;
    assign o_cfg_ready      = 1'b1;

    kbt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state    = r_state;
        n_dbg_down = r_dbg_down;
        n_code     = r_code;
        n_value    = r_value;
        n_frac     = r_frac;
        n_rptr     = r_rptr;
        n_wptr     = r_wptr;
        n_fidx     = r_fidx;
        n_fvalid   = r_fvalid;
        n_clr_idx  = r_clr_idx;
        n_clr_key  = r_clr_key;
        n_clr_lvl  = r_clr_lvl;
        n_clr_item = r_clr_item;
        n_ovalid   = r_ovalid && !i_ready;
        n_oval     = r_oval;
        n_ofrac    = r_ofrac;
        n_onon     = r_onon;
        key_raddr  = kidx;
        key_we     = 1'b0;
        key_waddr  = kidx;
        key_wdata  = r_key_rd;
        lvl_we     = 1'b0;
        lvl_waddr  = kidx;
        lvl_wdata  = sat_inc(r_lvl_rd);
        fifo_we    = 1'b0;
        fifo_wdata = r_code;
        filt_we    = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        delta      = r_now - r_key_rd.checked;
        held       = '0;
        w          = r_key_rd;
        code       = {1'b0, r_ctrl, r_alt, r_shift, 3'b0, r_key};
        if (dok && (r_debug == r_key || r_dbg_down)) begin
            code[15] = 1'b1;
        end

        case (r_state)
            ST_CLR: begin
                key_waddr = r_clr_idx;
                lvl_waddr = r_clr_idx;
                key_we    = r_clr_key;
                lvl_we    = r_clr_lvl;
                lvl_wdata = '0;
                key_wdata = '{down: 1'b0, went: r_now, held: '0, checked: r_now,
                              dcnt: '0, ucnt: '0};
                n_clr_idx = r_clr_idx + KW'(1);
                if (r_clr_idx == KW'(KEYS - 1)) begin
                    n_state = r_clr_item ? ST_RES : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_value = '0;
                    n_frac  = '0;
                    n_state = ST_DBG;
                end
            end
            ST_DBG: begin
                key_raddr = didx;
                n_state   = ST_KEY;
            end
            ST_KEY: begin
                n_dbg_down = r_key_rd.down;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_RES;
                case (r_func)
                    FN_EVENT: begin
                        if (kok) begin
                            key_we = 1'b1;
                            if (!r_kdown) begin
                                w.down = 1'b0;
                                w.ucnt = sat_inc(r_key_rd.ucnt);
                                w.held = (ev_t < r_key_rd.went) ? '0
                                         : r_key_rd.held + (ev_t - r_key_rd.went);
                            end else begin
                                if (!r_key_rd.down) begin
                                    w.went = ev_t;
                                    w.down = 1'b1;
                                    w.dcnt = sat_inc(r_key_rd.dcnt);
                                    lvl_we = 1'b1;
                                end
                                n_code = code;
                                if (code != 16'd0 && !full) begin
                                    if (r_filter_count == 7'd0) begin
                                        fifo_we    = 1'b1;
                                        fifo_wdata = code;
                                        n_wptr     = wnext;
                                    end else begin
                                        n_fidx   = '0;
                                        n_fvalid = 1'b0;
                                        n_state  = ST_FSCAN;
                                    end
                                end
                            end
                            key_wdata = w;
                        end
                    end
                    FN_POP: begin
                        if (r_rptr != r_wptr) begin
                            n_value = r_fifo_rd;
                            n_rptr  = rnext;
                        end
                    end
                    FN_DOWNS: begin
                        if (kok && knz) begin
                            n_value   = r_key_rd.dcnt;
                            w.dcnt    = '0;
                            key_wdata = w;
                            key_we    = 1'b1;
                        end
                    end
                    FN_UPS: begin
                        if (kok && knz) begin
                            n_value   = r_key_rd.ucnt;
                            w.ucnt    = '0;
                            key_wdata = w;
                            key_we    = 1'b1;
                        end
                    end
                    FN_FRAC: begin
                        if (kok && knz) begin
                            key_we    = 1'b1;
                            w.checked = r_now;
                            if (delta <= 32'd1) begin
                                w.went = r_now;
                                n_frac = r_key_rd.down ? Q_ONE : '0;
                            end else begin
                                if (!r_key_rd.down) begin
                                    held   = r_key_rd.held;
                                    w.held = '0;
                                end else begin
                                    held   = r_now - r_key_rd.went;
                                    w.went = r_now;
                                end
                                if (held >= delta) begin
                                    n_frac = Q_ONE;
                                end else begin
                                    div_start = 1'b1;
                                    div_num   = held;
                                    div_den   = delta;
                                    n_state   = ST_DIV;
                                end
                            end
                            key_wdata = w;
                        end
                    end
                    FN_FLUSH: begin
                        n_rptr     = '0;
                        n_wptr     = '0;
                        n_clr_idx  = '0;
                        n_clr_key  = 1'b1;
                        n_clr_lvl  = 1'b0;
                        n_clr_item = 1'b1;
                        n_state    = ST_CLR;
                    end
                    FN_LVLCLR: begin
                        n_clr_idx  = '0;
                        n_clr_key  = 1'b0;
                        n_clr_lvl  = 1'b1;
                        n_clr_item = 1'b1;
                        n_state    = ST_CLR;
                    end
                    FN_LVLRD: begin
                        if (kok) begin
                            n_value = r_lvl_rd;
                        end
                    end
                    FN_FILTER: begin
                        filt_we = {3'b0, r_fslot} < 9'(FILTER_SLOTS);
                    end
                    default: begin
                    end
                endcase
            end
            ST_FSCAN: begin
                if (r_fvalid && r_filt_rd == r_code) begin
                    fifo_we = 1'b1;
                    n_wptr  = wnext;
                    n_state = ST_RES;
                end else if ({{(9 - FCW){1'b0}}, r_fidx} == nlim) begin
                    n_state = ST_RES;
                end else begin
                    n_fidx   = r_fidx + FCW'(1);
                    n_fvalid = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_frac  = {1'b0, div_quot};
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_value;
                    n_ofrac  = r_frac;
                    n_onon   = r_rptr != r_wptr;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLR;
            r_clr_idx      <= '0;
            r_clr_key      <= 1'b1;
            r_clr_lvl      <= 1'b1;
            r_clr_item     <= 1'b0;
            r_now          <= '0;
            r_rptr         <= '0;
            r_wptr         <= '0;
            r_ovalid       <= 1'b0;
            r_filter_count <= '0;
            r_debug        <= 9'd53;
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_clr_key  <= n_clr_key;
            r_clr_lvl  <= n_clr_lvl;
            r_clr_item <= n_clr_item;
            r_rptr     <= n_rptr;
            r_wptr     <= n_wptr;
            r_ovalid   <= n_ovalid;
            if (r_state == ST_IDLE && i_valid) begin
                r_now <= i_now_ms;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FILTER_COUNT: r_filter_count <= i_cfg_data[6:0];
                    CFG_DEBUG_SCAN:   r_debug        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_func  <= i_func;
            r_key   <= i_scancode;
            r_kdown <= i_key_down;
            r_shift <= i_shift_held;
            r_alt   <= i_alt_held;
            r_ctrl  <= i_ctrl_held;
            r_lat   <= i_latency_ms;
            r_fslot <= i_filter_slot;
            r_fcode <= i_filter_code;
        end
        r_dbg_down <= n_dbg_down;
        r_code     <= n_code;
        r_value    <= n_value;
        r_frac     <= n_frac;
        r_fidx     <= n_fidx;
        r_fvalid   <= n_fvalid;
        r_oval     <= n_oval;
        r_ofrac    <= n_ofrac;
        r_onon     <= n_onon;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        r_key_rd <= key_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        r_lvl_rd <= lvl_mem[kidx];
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            fifo_mem[r_wptr] <= fifo_wdata;
        end
        r_fifo_rd <= fifo_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (filt_we) begin
            filt_mem[filt_waddr] <= r_fcode;
        end
        r_filt_rd <= filt_mem[filt_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/kbt_divider.sv =====
// Radix-2 restoring divider: 16 fraction bits of num/den, num below den.
`default_nettype none
module kbt_divider
    import kbt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [15:0]      o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_quot;
    logic [32:0] rem2;
    logic        fits;

    assign rem2 = {r_rem[31:0], 1'b0};
    assign fits = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? rem2 - {1'b0, r_den} : rem2;
                r_quot <= {r_quot[14:0], fits};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire
